// File: design/spq_pkg.sv
// spq_pkg: shared types and constants for the sorted priority queue
// used by spq_cell and sorted_priority_queue; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int PRIO_W    = 8;
    localparam int COUNT_W   = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [DATA_W-1:0] NEG_ONE = {DATA_W{1'b1}};

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic enq;
        logic deq;
        logic descending;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/sorted_priority_queue.sv
// sorted_priority_queue: bounded priority queue as a row of shift-insert cells
// each result is registered from the cycle in which its item is accepted
// throughput: one item per cycle when out_ready is high; every cell compares against the new priority at once
// the insertion point ripples along the row of DEPTH cells within that cycle
// reset clears the count, the order register and the result valid; cells hold no reset
// depends on spq_pkg and spq_cell
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire                                  op,
    input  wire  signed [spq_pkg::DATA_W-1:0]    data,
    input  wire         [spq_pkg::PRIO_W-1:0]    priority_req,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic        [1:0]                    status,
    output logic signed [spq_pkg::DATA_W-1:0]    dequeued_data,
    output logic signed [spq_pkg::DATA_W-1:0]    head_data,
    output logic signed [spq_pkg::DATA_W-1:0]    rear_data,
    output logic                                 is_empty,
    output logic        [spq_pkg::COUNT_W-1:0]   entry_count,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire                                  cfg_data
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              desc_reg;
    logic [DATA_W-1:0] rear_reg;
    logic [DATA_W-1:0] rear_next;

    logic              out_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [DATA_W-1:0] deq_data_reg;
    logic [DATA_W-1:0] deq_data_next;
    logic [DATA_W-1:0] head_reg;
    logic [DATA_W-1:0] head_next;
    logic [DATA_W-1:0] rear_out_reg;
    logic [DATA_W-1:0] rear_out_next;
    logic              empty_reg;
    logic [COUNT_W-1:0] cnt_out_reg;
    logic [31:0]       count_ext;

    logic              fire;
    logic              is_enq;
    logic              full;
    logic              enq_ok;
    logic              deq_ok;
    logic              appended;
    cell_ctrl_t        ctrl;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [PRIO_W-1:0] cell_prio [DEPTH];
    logic [DATA_W-1:0] cell_dnxt [DEPTH];
    logic [DEPTH-1:0]  hit_vec;
    logic [DEPTH:0]    found;

    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign fire      = in_valid && in_ready;
    assign is_enq    = (op == OP_ENQ);
    assign full      = (count_reg == CW'(DEPTH));
    assign enq_ok    = fire && is_enq && !full;
    assign deq_ok    = fire && (op == OP_DEQ) && (count_reg != '0);
    assign appended  = !(|hit_vec);

    assign ctrl.enq        = enq_ok;
    assign ctrl.deq        = deq_ok;
    assign ctrl.descending = desc_reg;

    assign found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .new_data   (data),
            .new_prio   (priority_req),
            .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
            .left_prio  (cell_prio[(i == 0) ? 0 : i - 1]),
            .right_data (cell_data[(i == DEPTH - 1) ? i : i + 1]),
            .right_prio (cell_prio[(i == DEPTH - 1) ? i : i + 1]),
            .found_in   (found[i]),
            .found_out  (found[i+1]),
            .hit        (hit_vec[i]),
            .data_q     (cell_data[i]),
            .prio_q     (cell_prio[i]),
            .data_nxt   (cell_dnxt[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (enq_ok)
            count_next = count_reg + CW'(1);
        else if (deq_ok)
            count_next = count_reg - CW'(1);

        // rear only moves when the new item lands behind every held entry
        rear_next = rear_reg;
        if (enq_ok && appended)
            rear_next = data;

        if (is_enq)
            status_next = full ? ST_FULL : ST_OK;
        else
            status_next = (count_reg == '0) ? ST_EMPTY : ST_OK;

        deq_data_next = deq_ok ? cell_data[0] : NEG_ONE;
        head_next     = (count_next != '0) ? cell_dnxt[0] : '0;
        rear_out_next = (count_next != '0) ? rear_next : '0;
        count_ext     = 32'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            desc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                desc_reg <= cfg_data;
            if (fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rear_reg <= rear_next;
        if (fire)
        begin
            status_reg   <= status_next;
            deq_data_reg <= deq_data_next;
            head_reg     <= head_next;
            rear_out_reg <= rear_out_next;
            empty_reg    <= (count_next == '0);
            cnt_out_reg  <= count_ext[COUNT_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign dequeued_data = deq_data_reg;
    assign head_data     = head_reg;
    assign rear_data     = rear_out_reg;
    assign is_empty      = empty_reg;
    assign entry_count   = cnt_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        enq_ok |=> count_reg == $past(count_reg) + CW'(1))
        else $error("enqueue did not grow the count");

    a_empty_deq: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !is_enq && count_reg == '0 |=> out_valid_reg && status_reg == ST_EMPTY
            && deq_data_reg == NEG_ONE)
        else $error("dequeue on empty queue not reported");

    a_deq_head: assert property (@(posedge clk) disable iff (!rst_n)
        deq_ok |=> deq_data_reg == $past(cell_data[0]) && status_reg == ST_OK)
        else $error("dequeued item is not the old head");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_enq && full |=> count_reg == CW'(DEPTH) && status_reg == ST_FULL)
        else $error("enqueue on full queue changed state");

endmodule

`default_nettype wire

// File: design/spq_cell.sv
// spq_cell: one slot of the sorted store with shift-insert and shift-out
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  wire                              clk,
    input  spq_pkg::cell_ctrl_t              ctrl,
    input  wire  [CW-1:0]                    count,
    input  wire  [spq_pkg::DATA_W-1:0]       new_data,
    input  wire  [spq_pkg::PRIO_W-1:0]       new_prio,
    input  wire  [spq_pkg::DATA_W-1:0]       left_data,
    input  wire  [spq_pkg::PRIO_W-1:0]       left_prio,
    input  wire  [spq_pkg::DATA_W-1:0]       right_data,
    input  wire  [spq_pkg::PRIO_W-1:0]       right_prio,
    input  wire                              found_in,
    output logic                             found_out,
    output logic                             hit,
    output logic [spq_pkg::DATA_W-1:0]       data_q,
    output logic [spq_pkg::PRIO_W-1:0]       prio_q,
    output logic [spq_pkg::DATA_W-1:0]       data_nxt
);
    import spq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic              occupied;
    logic              goes_after;
    logic              after;

    always_comb
    begin
        occupied   = count > CW'(INDEX);
        goes_after = ctrl.descending ? (prio_reg < new_prio) : (prio_reg > new_prio);
        hit        = occupied && goes_after;
        // free slots count as insertion points so an append lands at the rear
        after      = !occupied || goes_after;
        found_out  = found_in || after;

        data_next = data_reg;
        prio_next = prio_reg;
        if (ctrl.enq)
        begin
            if (found_in)
            begin
                data_next = left_data;
                prio_next = left_prio;
            end
            else if (after)
            begin
                data_next = new_data;
                prio_next = new_prio;
            end
        end
        else if (ctrl.deq)
        begin
            data_next = right_data;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign data_q   = data_reg;
    assign prio_q   = prio_reg;
    assign data_nxt = data_next;

endmodule

`default_nettype wire
